/* rtl/obd_pkg.sv */
// Package for the OBD-II mode 01 response decoder: item and result types,
// the classified job passed from front to back, and the scaling constants.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package obd_pkg;

  localparam int unsigned MAX_BYTES_DEF = 8;
  localparam int unsigned JOB_DEPTH     = 2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_PROMPT = 8'h3E;

  localparam logic [7:0] MODE01_REPLY = 8'h41;
  localparam logic [7:0] PID_RPM      = 8'h0C;
  localparam logic [7:0] PID_SPEED    = 8'h0D;
  localparam logic [7:0] PID_VOLTS    = 8'h42;
  localparam logic [7:0] PID_PCT      = 8'h5B;

  localparam int unsigned VALUE_W = 22;
  localparam int unsigned X_W     = 24;
  localparam int unsigned M_W     = 25;
  localparam int unsigned P_W     = X_W + M_W;

  // percent = A*100/255 in Q8: x = A*25600, then divide by 255.
  localparam logic [X_W-1:0] PCT_SCALE = X_W'(25600);
  // Exact reciprocals: floor(x/d) = (x*M) >> S for every x below 2^24.
  localparam logic [M_W-1:0] RECIP_1000 = M_W'(17179870);
  localparam int unsigned    SHIFT_1000 = 34;
  localparam logic [M_W-1:0] RECIP_255  = M_W'(8421505);
  localparam int unsigned    SHIFT_255  = 31;

  typedef struct packed {
    logic [7:0] ch;
    logic [7:0] pid;
    logic       last;
  } obd_in_t;

  typedef struct packed {
    logic               ok;
    logic [VALUE_W-1:0] value_q8;
  } obd_out_t;

  typedef enum logic [2:0] {
    KIND_FAIL  = 3'd0,
    KIND_RPM   = 3'd1,
    KIND_SPEED = 3'd2,
    KIND_VOLTS = 3'd3,
    KIND_PCT   = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] a;
    logic [7:0] b;
  } obd_job_t;

  // Bit 4 set marks a valid hex digit of either case; bits 3:0 give its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/obd_front.sv */
// Front part: parses characters into bytes and, on the last character of a
// line, classifies the line into a job for the back part. Uses obd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module obd_front #(
  parameter int unsigned MaxBytes = obd_pkg::MAX_BYTES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,
  input  wire obd_pkg::obd_in_t  item_i,
  output logic                   job_push_o,
  output obd_pkg::obd_job_t      job_o
);
  import obd_pkg::*;

  localparam int unsigned CW = $clog2(MaxBytes + 1);

  typedef enum logic [2:0] {
    PH_HIGH = 3'b001,
    PH_LOW  = 3'b010,
    PH_STOP = 3'b100
  } phase_e;

  phase_e        ph_q, ph_d;
  logic [3:0]    hn_q, hn_d;
  logic [CW-1:0] cnt_q, cnt_d, cnt_new;
  logic [7:0]    fb_q [4];
  logic [7:0]    nb   [4];
  logic [4:0]    dig;
  logic          wr;
  logic [7:0]    new_byte;
  logic          has3, has4, hdr_ok;

  assign dig      = hex_digit(item_i.ch);
  assign new_byte = {hn_q, dig[3:0]};

  always_comb begin
    ph_d    = ph_q;
    hn_d    = hn_q;
    cnt_new = cnt_q;
    wr      = 1'b0;
    if (item_i.ch == CH_NUL) begin
      ph_d = PH_STOP;
    end else begin
      unique case (ph_q)
        PH_HIGH: begin
          if (item_i.ch == CH_PROMPT) begin
            ph_d = PH_STOP;
          end else if (item_i.ch != CH_SPACE) begin
            if (dig[4]) begin
              hn_d = dig[3:0];
              ph_d = PH_LOW;
            end else begin
              ph_d = PH_STOP;
            end
          end
        end
        PH_LOW: begin
          if (dig[4]) begin
            wr      = 1'b1;
            cnt_new = cnt_q + CW'(1);
            ph_d    = (cnt_new >= CW'(MaxBytes)) ? PH_STOP : PH_HIGH;
          end else begin
            ph_d = PH_STOP;
          end
        end
        PH_STOP: ;
        default: ph_d = PH_STOP;
      endcase
    end
    cnt_d = cnt_new;
    if (item_i.last) begin
      ph_d  = PH_HIGH;
      hn_d  = 4'd0;
      cnt_d = '0;
    end
  end

  // Byte view including the character being taken now.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nb[i] = (wr && cnt_q == CW'(i)) ? new_byte : fb_q[i];
    end
  end

  assign has3   = cnt_new >= CW'(3);
  assign has4   = cnt_new >= CW'(4);
  assign hdr_ok = has3 && nb[0] == MODE01_REPLY && nb[1] == item_i.pid;

  always_comb begin
    job_o.a    = nb[2];
    job_o.b    = nb[3];
    job_o.kind = KIND_FAIL;
    if (hdr_ok) begin
      unique case (item_i.pid)
        PID_RPM:   job_o.kind = has4 ? KIND_RPM : KIND_FAIL;
        PID_SPEED: job_o.kind = KIND_SPEED;
        PID_VOLTS: job_o.kind = has4 ? KIND_VOLTS : KIND_FAIL;
        PID_PCT:   job_o.kind = KIND_PCT;
        default:   job_o.kind = KIND_FAIL;
      endcase
    end
  end

  assign job_push_o = take_i && item_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_HIGH;
      hn_q  <= 4'd0;
      cnt_q <= '0;
    end else if (take_i) begin
      ph_q  <= ph_d;
      hn_q  <= hn_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && wr) begin
      for (int i = 0; i < 4; i++) begin
        if (cnt_q == CW'(i)) begin
          fb_q[i] <= new_byte;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/obd_jobq.sv */
// Short job queue between front and back, so each side stalls on its own.
// Uses obd_pkg for the job type and depth.
`timescale 1ns / 1ps
`default_nettype none

module obd_jobq (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire obd_pkg::obd_job_t  job_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    nonempty_o,
  output obd_pkg::obd_job_t       job_o
);
  import obd_pkg::*;

  localparam int unsigned PW = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
  localparam int unsigned NW = $clog2(JOB_DEPTH + 1);

  obd_job_t      mem_q [JOB_DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [NW-1:0] n_q;
  logic          do_push, do_pop;

  assign full_o     = n_q == NW'(JOB_DEPTH);
  assign nonempty_o = n_q != '0;
  assign job_o      = mem_q[rp_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && nonempty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      n_q  <= '0;
    end else begin
      if (do_push) begin
        wp_q <= (wp_q == PW'(JOB_DEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (do_pop) begin
        rp_q <= (rp_q == PW'(JOB_DEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        n_q <= n_q + NW'(1);
      end else if (do_pop && !do_push) begin
        n_q <= n_q - NW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/obd_back.sv */
// Back part: scales a classified job into the Q8 result through a short
// multiply pipeline and holds it in the output register. Uses obd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module obd_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               job_valid_i,
  input  wire obd_pkg::obd_job_t  job_i,
  output logic                    job_pop_o,
  output logic                    empty_o,
  input  wire logic               pop_i,
  output obd_pkg::obd_out_t       result_o
);
  import obd_pkg::*;

  logic               en;
  // Stage A: operand prepared
  logic               va_q;
  kind_e              ka_q;
  logic [X_W-1:0]     xa_q, xa_d;
  logic [VALUE_W-1:0] da_q, da_d;
  // Stage B: product taken
  logic               vb_q;
  kind_e              kb_q;
  logic [P_W-1:0]     pb_q;
  logic [VALUE_W-1:0] db_q;
  logic [M_W-1:0]     recip;
  // Output register
  logic               vo_q;
  obd_out_t           res_q, res_d;

  assign en        = !vo_q || pop_i;
  assign job_pop_o = en && job_valid_i;
  assign empty_o   = !vo_q;
  assign result_o  = res_q;

  always_comb begin
    xa_d = X_W'(job_i.a) * PCT_SCALE;
    da_d = '0;
    case (job_i.kind)
      KIND_VOLTS: xa_d = {job_i.a, job_i.b, 8'd0};
      KIND_RPM:   da_d = VALUE_W'({job_i.a, job_i.b, 6'd0});
      KIND_SPEED: da_d = VALUE_W'({job_i.a, 8'd0});
      default:    ;
    endcase
  end

  assign recip = (ka_q == KIND_VOLTS) ? RECIP_1000 : RECIP_255;

  always_comb begin
    res_d.ok       = kb_q != KIND_FAIL;
    res_d.value_q8 = db_q;
    case (kb_q)
      KIND_VOLTS: res_d.value_q8 = VALUE_W'(pb_q >> SHIFT_1000);
      KIND_PCT:   res_d.value_q8 = VALUE_W'(pb_q >> SHIFT_255);
      KIND_FAIL:  res_d.value_q8 = '0;
      default:    ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en) begin
      va_q <= job_valid_i;
      vb_q <= va_q;
      vo_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ka_q  <= job_i.kind;
      xa_q  <= xa_d;
      da_q  <= da_d;
      kb_q  <= ka_q;
      pb_q  <= P_W'(xa_q) * P_W'(recip);
      db_q  <= da_q;
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/obd_mode01_response_decoder.sv */
// OBD-II mode 01 response decoder, top level; uses obd_pkg, obd_front,
// obd_jobq and obd_back. Takes one character item per cycle while the job
// queue is not full. Once its last character is accepted, a line's result
// passes the job queue, operand stage, multiply stage and output register.
// Reset clears the parser, queue pointers and pipeline valid bits; the
// stored bytes of a line need no reset, since they are rewritten each line.
`timescale 1ns / 1ps
`default_nettype none

module obd_mode01_response_decoder #(
  parameter int unsigned MaxBytes = obd_pkg::MAX_BYTES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push,
  output logic                  full,
  input  wire obd_pkg::obd_in_t item_i,
  output logic                  empty,
  input  wire logic             pop,
  output obd_pkg::obd_out_t     result_o
);
  import obd_pkg::*;

  logic     take;
  logic     job_push;
  obd_job_t job_in;
  logic     q_full;
  logic     q_nonempty;
  logic     q_pop;
  obd_job_t job_out;

  // Characters are refused only when the job queue is full. The back part
  // drains the queue whenever its output register is free or being popped,
  // so a waiting result stops the front only once the queue has filled.
  assign full = q_full;
  assign take = push && !q_full;

  // The front parses every character and, on the last one of a line,
  // classifies the line (header check, PID, byte count) into a job.
  obd_front #(
    .MaxBytes(MaxBytes)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .item_i    (item_i),
    .job_push_o(job_push),
    .job_o     (job_in)
  );

  // Two-entry queue decouples parsing from scaling.
  obd_jobq u_jobq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (job_push),
    .job_i     (job_in),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .nonempty_o(q_nonempty),
    .job_o     (job_out)
  );

  // The back part scales the value with exact reciprocal multiplies for the
  // divisions by 1000 and 255, and presents the result as a queue head.
  obd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_nonempty),
    .job_i      (job_out),
    .job_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .result_o   (result_o)
  );

endmodule

`default_nettype wire
